// File: rtl/core/utf8st_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the UTF-8 sanitizer.
package utf8st_pkg;

	localparam logic [7:0]  REPL_BYTE   = 8'h3F;
	localparam logic [7:0]  DEL_BYTE    = 8'h7F;
	localparam logic [7:0]  SPACE_BYTE  = 8'h20;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00DFFF;
	localparam logic [20:0] MIN_LEN2    = 21'h000080;
	localparam logic [20:0] MIN_LEN3    = 21'h000800;
	localparam logic [20:0] MIN_LEN4    = 21'h010000;
	localparam logic [15:0] LIMIT_RESET = 16'd256;

	typedef enum logic [1:0] {
		ACT_STOP,
		ACT_ONE,
		ACT_WAIT,
		ACT_SEQ
	} scan_act_t;

	typedef struct packed {
		scan_act_t  act;
		logic [7:0] out_byte;
		logic [2:0] len;
	} scan_res_t;

endpackage

// File: rtl/core/utf8st_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the byte, result and limit channels.
interface utf8st_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source (output valid, output in_byte, output in_final, input ready);
	modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface utf8st_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_end;
	logic       run_last;

	modport source (output valid, output out_byte, output is_end, output run_last, input ready);
	modport sink   (input valid, input out_byte, input is_end, input run_last, output ready);
endinterface

interface utf8st_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] output_limit;

	modport source (output valid, output output_limit, input ready);
	modport sink   (input valid, input output_limit, output ready);
endinterface

// File: rtl/core/utf8st_check.sv
`timescale 1ns / 1ps
// Shared scan unit: classifies the byte window head and checks room left.
module utf8st_check (
	input  logic [3:0][7:0]        win,
	input  logic [2:0]             avail,
	input  logic                   final_flag,
	input  logic [15:0]            emitted,
	input  logic [15:0]            limit,
	output utf8st_pkg::scan_res_t  res
);

	logic [7:0]  lead;
	logic [2:0]  lead_len;
	logic [20:0] cp;
	logic [20:0] cp_min;
	logic        cont_ok;
	logic        seq_ok;
	logic [15:0] room;

	assign lead = win[0];
	assign room = limit - emitted;

	always_comb begin
		lead_len = 3'd0;
		cp_min   = 21'd0;
		if (lead[7:5] == 3'b110) begin
			lead_len = 3'd2;
			cp_min   = utf8st_pkg::MIN_LEN2;
		end else if (lead[7:4] == 4'b1110) begin
			lead_len = 3'd3;
			cp_min   = utf8st_pkg::MIN_LEN3;
		end else if (lead[7:3] == 5'b11110) begin
			lead_len = 3'd4;
			cp_min   = utf8st_pkg::MIN_LEN4;
		end
	end

	always_comb begin
		case (lead_len)
			3'd2: cp = {10'd0, lead[4:0], win[1][5:0]};
			3'd3: cp = {5'd0, lead[3:0], win[1][5:0], win[2][5:0]};
			3'd4: cp = {lead[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
			default: cp = 21'd0;
		endcase
	end

	always_comb begin
		cont_ok = 1'b1;
		for (int i = 1; i < 4; i++) begin
			if (3'(i) < lead_len && win[i][7:6] != 2'b10) cont_ok = 1'b0;
		end
	end

	assign seq_ok = cont_ok && cp >= cp_min && cp <= utf8st_pkg::CP_MAX &&
	                !(cp >= utf8st_pkg::SURR_LO && cp <= utf8st_pkg::SURR_HI);

	always_comb begin
		res.act      = utf8st_pkg::ACT_ONE;
		res.out_byte = utf8st_pkg::REPL_BYTE;
		res.len      = lead_len;
		if (emitted >= limit) begin
			res.act = utf8st_pkg::ACT_STOP;
		end else if (!lead[7]) begin
			if (lead >= utf8st_pkg::SPACE_BYTE && lead != utf8st_pkg::DEL_BYTE)
				res.out_byte = lead;
		end else if (lead_len == 3'd0) begin
			res.act = utf8st_pkg::ACT_ONE;
		end else if (avail < lead_len) begin
			if (!final_flag) res.act = utf8st_pkg::ACT_WAIT;
		end else if (!seq_ok) begin
			res.act = utf8st_pkg::ACT_ONE;
		end else if ({13'd0, lead_len} > room) begin
			res.act = utf8st_pkg::ACT_STOP;
		end else begin
			res.act = utf8st_pkg::ACT_SEQ;
		end
	end

endmodule

// File: rtl/core/utf8_sanitize_truncate.sv
`timescale 1ns / 1ps
// UTF-8 sanitizer with per-string output limit: top level.
//
// raw: one string byte per beat, in_final on the last byte of a string.
// clean: result beats; sanitized bytes, then one end beat (is_end=1,
//   out_byte=0) after the final byte. run_last marks the last beat that
//   one input byte causes.
// cfg: writes output_limit; always ready, write it only while idle.
// Each accepted byte runs through a small sequencer that calls one shared
// scan unit per buffered byte: accept, one scan step per byte replaced or
// sequence found, one copy step per byte copied, then an empty-buffer scan,
// an end step and a flush step. A byte that waits for more bytes or stops
// output skips the empty scan, and a byte after output stopped goes from
// accept straight to the end step. raw is ready only between bytes.
// The last result of a byte is held in a staging register until its
// run_last bit is known, then moved to the output register; a stalled
// receiver holds the output register and the sequencer waits on it.
// Reset clears all string state and loads output_limit with 256.
module utf8_sanitize_truncate (
	input  logic                 clk,
	input  logic                 arst_n,
	utf8st_byte_if.sink          raw,
	utf8st_res_if.source         clean,
	utf8st_cfg_if.sink           cfg
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COPY,
		ST_FIN,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [3:0][7:0]        buf_q;
	logic [2:0]             n_q;
	logic [2:0]             cnt_q;
	logic                   final_q;
	logic                   stopped_q;
	logic [15:0]            emitted_q;
	logic [15:0]            limit_q;
	logic                   pend_v_q;
	logic [7:0]             pend_byte_q;
	logic                   pend_end_q;
	logic                   out_v_q;
	logic [7:0]             out_byte_q;
	logic                   out_end_q;
	logic                   out_last_q;

	utf8st_pkg::scan_res_t  res;
	logic                   out_free;
	logic                   can_put;
	logic                   put_en;
	logic [7:0]             put_byte;
	logic                   put_end;
	logic                   fwd_en;
	logic                   fwd_last;

	utf8st_check u_check (
		.win        (buf_q),
		.avail      (n_q),
		.final_flag (final_q),
		.emitted    (emitted_q),
		.limit      (limit_q),
		.res        (res)
	);

	assign raw.ready      = (state_q == ST_IDLE);
	assign cfg.ready      = 1'b1;
	assign clean.valid    = out_v_q;
	assign clean.out_byte = out_byte_q;
	assign clean.is_end   = out_end_q;
	assign clean.run_last = out_last_q;

	assign out_free = !out_v_q || clean.ready;
	assign can_put  = !pend_v_q || out_free;
	assign fwd_en   = pend_v_q && (put_en || (state_q == ST_FLUSH && out_free));
	assign fwd_last = (state_q == ST_FLUSH);

	always_comb begin
		put_en   = 1'b0;
		put_byte = res.out_byte;
		put_end  = 1'b0;
		case (state_q)
			ST_SCAN: put_en = (n_q != 3'd0) && (res.act == utf8st_pkg::ACT_ONE) && can_put;
			ST_COPY: begin
				put_en   = can_put;
				put_byte = buf_q[0];
			end
			ST_FIN: begin
				put_en   = final_q && can_put;
				put_byte = 8'd0;
				put_end  = 1'b1;
			end
			default: put_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			buf_q       <= '0;
			n_q         <= 3'd0;
			cnt_q       <= 3'd0;
			final_q     <= 1'b0;
			stopped_q   <= 1'b0;
			emitted_q   <= 16'd0;
			limit_q     <= utf8st_pkg::LIMIT_RESET;
			pend_v_q    <= 1'b0;
			pend_byte_q <= 8'd0;
			pend_end_q  <= 1'b0;
			out_v_q     <= 1'b0;
			out_byte_q  <= 8'd0;
			out_end_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg.valid) limit_q <= cfg.output_limit;

			// staged beat moves out once a newer one exists or the byte is done
			if (fwd_en) begin
				out_v_q    <= 1'b1;
				out_byte_q <= pend_byte_q;
				out_end_q  <= pend_end_q;
				out_last_q <= fwd_last;
			end else if (clean.ready) begin
				out_v_q <= 1'b0;
			end

			if (put_en) begin
				pend_v_q    <= 1'b1;
				pend_byte_q <= put_byte;
				pend_end_q  <= put_end;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (raw.valid) begin
						final_q <= raw.in_final;
						if (!stopped_q) begin
							buf_q[n_q[1:0]] <= raw.in_byte;
							n_q             <= n_q + 3'd1;
							state_q         <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (n_q == 3'd0) begin
						state_q <= ST_FIN;
					end else begin
						unique case (res.act)
							utf8st_pkg::ACT_STOP: begin
								stopped_q <= 1'b1;
								n_q       <= 3'd0;
								state_q   <= ST_FIN;
							end
							utf8st_pkg::ACT_WAIT: state_q <= ST_FIN;
							utf8st_pkg::ACT_ONE: begin
								if (put_en) begin
									buf_q     <= {8'd0, buf_q[3:1]};
									n_q       <= n_q - 3'd1;
									emitted_q <= emitted_q + 16'd1;
								end
							end
							utf8st_pkg::ACT_SEQ: begin
								cnt_q     <= res.len;
								emitted_q <= emitted_q + {13'd0, res.len};
								state_q   <= ST_COPY;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_COPY: begin
					if (put_en) begin
						buf_q <= {8'd0, buf_q[3:1]};
						n_q   <= n_q - 3'd1;
						cnt_q <= cnt_q - 3'd1;
						if (cnt_q == 3'd1) state_q <= ST_SCAN;
					end
				end
				ST_FIN: begin
					if (!final_q) begin
						state_q <= ST_FLUSH;
					end else if (put_en) begin
						n_q       <= 3'd0;
						emitted_q <= 16'd0;
						stopped_q <= 1'b0;
						state_q   <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_no_stage: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q && n_q <= 3'd3)
		else $error("staged beat or full buffer while idle");

	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> cnt_q != 3'd0 && cnt_q <= n_q)
		else $error("copy count out of range");

	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_end_q |-> out_last_q && out_byte_q == 8'd0)
		else $error("end beat malformed");

	a_stop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && state_q == ST_IDLE |-> n_q == 3'd0)
		else $error("bytes held after output stopped");

endmodule
